FILE: src/rws_pkg.sv
package rws_pkg;

  // Default table depth.
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  // Field widths fixed by the request and response formats.
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned FIT_W   = 16;
  localparam int unsigned INDEX_W = 6;

  // Fitness saturation point, 100.0 in unsigned Q8.8.
  localparam logic [FIT_W-1:0] FIT_CAP = 16'd25600;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_APPEND  = 2'd1,
    OP_DRAW    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_SELECTED = 2'd1,
    ST_NONE     = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    op_e               opcode;
    logic [FIT_W-1:0]  fitness_value;
    logic [FRAC_W-1:0] random_fraction;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [INDEX_W-1:0] selected_index;
  } rsp_t;

endpackage

FILE: src/rws_cell.sv
module rws_cell #(
  parameter int unsigned AW     = 6,
  parameter int unsigned BitPos = 0,
  parameter int unsigned PW     = 21,
  parameter int unsigned TW     = 37
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [AW-1:0] idx_i,
  input  logic [AW:0]   count_i,
  input  logic [TW-1:0] target_i,
  input  logic [PW-1:0] rdata_i,
  output logic          vld_o,
  output logic [AW-1:0] idx_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o
);
  import rws_pkg::*;

  localparam logic [AW-1:0] LowMask = AW'((1 << BitPos) - 1);
  localparam logic [AW:0]   Step    = (AW+1)'(1 << BitPos);

  logic          vld_q;
  logic [AW-1:0] idx_q;
  logic [AW:0]   cand;
  logic          take;

  // The probe for this bit reads the last entry of the candidate span.
  assign rd_en_o   = vld_i;
  assign rd_addr_o = idx_i | LowMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      idx_q <= idx_i;
    end
  end

  // Skip the span when all its entries exist and its last prefix is below the target.
  // The skip never reaches the full table size, since the last prefix equals the total.
  always_comb begin
    cand  = {1'b0, idx_q} + Step;
    take  = (cand <= count_i) && ({rdata_i, {FRAC_W{1'b0}}} < target_i);
    idx_o = take ? cand[AW-1:0] : idx_q;
  end

  assign vld_o = vld_q;

endmodule

FILE: src/roulette_wheel_select.sv
// Restart, append, unused opcodes and draws on an empty or zero-weight table answer
// in the cycle after the request is accepted, one request per cycle while not stalled.
// A searching draw passes through the search cells, one per index bit, each making one
// probe of the single read port of the prefix memory, and then the output register.
// Reset is asynchronous and active low; it empties the table and the output register.
// The prefix memory is not cleared.
module roulette_wheel_select #(
  parameter int unsigned MAX_ENTRIES = rws_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rws_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rws_pkg::rsp_t out_rsp_o
);
  import rws_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned PW = $clog2(MAX_ENTRIES * 25600 + 1);
  localparam int unsigned TW = FRAC_W + PW;

  logic [AW:0]    count_q, count_d;
  logic [PW-1:0]  total_q, total_d;
  logic [TW-1:0]  target_q;
  logic           busy_q, busy_d;
  logic           out_valid_q, out_valid_d;
  rsp_t           out_rsp_q, out_rsp_d;
  logic [PW-1:0]  prefix_mem [MAX_ENTRIES];
  logic [PW-1:0]  rdata_q;

  logic           accept;
  logic           full;
  logic           draw_go;
  logic           done;
  logic           out_load;
  logic [FIT_W-1:0] fit_sat;
  logic [PW-1:0]  sum;

  logic [AW:0]    vld_c;
  logic [AW-1:0]  idx_c   [AW+1];
  logic [AW-1:0]  rd_en;
  logic [AW-1:0]  rd_addr_c [AW];
  logic [AW-1:0]  rd_addr;
  logic           rd_any;

  // Request handshake: no request is taken while a draw is searching or a response is stalled.
  assign in_stall_o = busy_q | (out_valid_q & out_stall_i);
  assign accept     = in_valid_i & ~in_stall_o;

  assign full    = (count_q == (AW+1)'(MAX_ENTRIES));
  assign fit_sat = (in_req_i.fitness_value > FIT_CAP) ? FIT_CAP : in_req_i.fitness_value;
  assign sum     = total_q + PW'(fit_sat);
  assign draw_go = accept && (in_req_i.opcode == OP_DRAW) &&
                   (count_q != '0) && (total_q != '0);
  assign done    = vld_c[AW];

  // Search chain: each cell settles one index bit, most significant first.
  assign vld_c[0] = draw_go;
  assign idx_c[0] = '0;

  for (genvar k = 0; k < AW; k++) begin : g_cell
    rws_cell #(
      .AW    (AW),
      .BitPos(AW - 1 - k),
      .PW    (PW),
      .TW    (TW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .vld_i    (vld_c[k]),
      .idx_i    (idx_c[k]),
      .count_i  (count_q),
      .target_i (target_q),
      .rdata_i  (rdata_q),
      .vld_o    (vld_c[k+1]),
      .idx_o    (idx_c[k+1]),
      .rd_en_o  (rd_en[k]),
      .rd_addr_o(rd_addr_c[k])
    );
  end

  // Only one cell probes at a time, so the addresses merge by OR.
  always_comb begin
    rd_addr = '0;
    for (int k = 0; k < AW; k++) begin
      rd_addr = rd_addr | (rd_en[k] ? rd_addr_c[k] : '0);
    end
  end
  assign rd_any = |rd_en;

  // Prefix memory: appends write at the fill count, the search reads one entry a cycle.
  always_ff @(posedge clk_i) begin
    if (accept && (in_req_i.opcode == OP_APPEND) && !full) begin
      prefix_mem[count_q[AW-1:0]] <= sum;
    end
    if (rd_any && (rd_addr < AW'(MAX_ENTRIES - 1)) || (rd_any && rd_addr == AW'(MAX_ENTRIES - 1))) begin
      rdata_q <= prefix_mem[rd_addr];
    end
  end

  // Scaled target for the draw: fraction times total.
  always_ff @(posedge clk_i) begin
    if (draw_go) begin
      target_q <= TW'(in_req_i.random_fraction) * TW'(total_q);
    end
  end

  // Table state and response next values.
  always_comb begin
    count_d   = count_q;
    total_d   = total_q;
    busy_d    = busy_q;
    out_load  = 1'b0;
    out_rsp_d = out_rsp_q;
    priority if (done) begin
      busy_d                   = 1'b0;
      out_load                 = 1'b1;
      out_rsp_d.status         = ST_SELECTED;
      out_rsp_d.selected_index = INDEX_W'(idx_c[AW]);
    end else if (accept) begin
      out_rsp_d.selected_index = '0;
      unique case (in_req_i.opcode)
        OP_RESTART: begin
          count_d          = '0;
          total_d          = '0;
          out_load         = 1'b1;
          out_rsp_d.status = ST_ACCEPTED;
        end
        OP_APPEND: begin
          out_load = 1'b1;
          if (full) begin
            out_rsp_d.status = ST_FULL;
          end else begin
            count_d          = count_q + 1'b1;
            total_d          = sum;
            out_rsp_d.status = ST_ACCEPTED;
          end
        end
        OP_DRAW: begin
          if (draw_go) begin
            busy_d = 1'b1;
          end else begin
            out_load         = 1'b1;
            out_rsp_d.status = ST_NONE;
          end
        end
        default: begin
          out_load         = 1'b1;
          out_rsp_d.status = ST_NONE;
        end
      endcase
    end
    out_valid_d = out_load | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      total_q     <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      total_q     <= total_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef NO_ASSERTIONS
  // At most one search cell is active at a time.
  a_one_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_c))
    else $error("more than one search cell active");

  // The output register stays empty while a draw is searching.
  a_busy_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !out_valid_q)
    else $error("response pending during a search");

  // A search only finishes while a draw is in progress.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy_q)
    else $error("search finished without a draw in progress");

  // The fill count never passes the table size.
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (AW+1)'(MAX_ENTRIES))
    else $error("entry count beyond table size");
`endif

endmodule

FILE: bench/roulette_wheel_select_checker.sv
`timescale 1ns / 100ps

module roulette_wheel_select_checker #(
  parameter int unsigned MAX_ENTRIES = rws_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  rws_pkg::req_t in_req_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  rws_pkg::rsp_t out_rsp_i,
  output int unsigned   mismatch_count_o,
  output int unsigned   pending_o,
  output int unsigned   request_count_o,
  output int unsigned   selected_count_o,
  output int unsigned   no_pick_count_o,
  output int unsigned   dropped_count_o
);
  import rws_pkg::*;

  // Prefix sums need enough bits to hold a full table of saturated fitness values.
  localparam int unsigned SUM_W   = $clog2(MAX_ENTRIES * FIT_CAP + 1);
  localparam int unsigned COUNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_ENTRIES);
  localparam int unsigned PROD_W  = FRAC_W + SUM_W;

  // Shadow copy of the selection table.
  logic [SUM_W-1:0]   wheel_prefix [MAX_ENTRIES];
  logic [COUNT_W-1:0] wheel_size;
  logic [SUM_W-1:0]   wheel_total;

  rsp_t        expected_rsp_q [$];
  rsp_t        oldest_rsp;
  rsp_t        next_rsp;
  int unsigned n_mismatch;
  int unsigned n_request;
  int unsigned n_response;
  int unsigned n_selected;
  int unsigned n_no_pick;
  int unsigned n_dropped;

  // Finds the first entry whose share of the wheel covers the drawn fraction.
  function automatic logic [INDEX_W-1:0] spin_wheel(logic [FRAC_W-1:0] fraction);
    logic [PROD_W-1:0] target;
    logic [PROD_W-1:0] probe;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    target = PROD_W'(fraction) * PROD_W'(wheel_total);
    lo = 0;
    hi = wheel_size;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      probe = {wheel_prefix[IDX_W'(mid)], {FRAC_W{1'b0}}};
      if (target <= probe) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    // The last prefix equals the total, so the search never runs off the end.
    if (lo >= wheel_size) begin
      lo = wheel_size - 1;
    end
    return INDEX_W'(lo);
  endfunction

  // Applies one request to the shadow table and returns the response it must cause.
  function automatic rsp_t apply_request(req_t req);
    rsp_t             rsp;
    logic [FIT_W-1:0] fit;
    rsp = '{status: ST_ACCEPTED, selected_index: '0};
    case (req.opcode)
      OP_RESTART: begin
        wheel_size  = '0;
        wheel_total = '0;
      end
      OP_APPEND: begin
        if (wheel_size >= MAX_ENTRIES) begin
          rsp.status = ST_FULL;
        end else begin
          fit = (req.fitness_value > FIT_CAP) ? FIT_CAP : req.fitness_value;
          wheel_total = wheel_total + SUM_W'(fit);
          wheel_prefix[wheel_size[IDX_W-1:0]] = wheel_total;
          wheel_size = wheel_size + 1'b1;
        end
      end
      OP_DRAW: begin
        if (wheel_size == 0 || wheel_total == 0) begin
          rsp.status = ST_NONE;
        end else begin
          rsp.status = ST_SELECTED;
          rsp.selected_index = spin_wheel(req.random_fraction);
        end
      end
      default: begin
        // The unused opcode leaves the table alone and reports no selection.
        rsp.status = ST_NONE;
      end
    endcase
    return rsp;
  endfunction

  task automatic flag_error(input string msg);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("[%0t] MISMATCH %s", $realtime, msg);
    end
  endtask

  // Compare completed responses first, then queue the prediction for a new request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rsp_q.delete();
      wheel_size  = '0;
      wheel_total = '0;
      n_mismatch  = 0;
      n_request   = 0;
      n_response  = 0;
      n_selected  = 0;
      n_no_pick   = 0;
      n_dropped   = 0;
      mismatch_count_o <= 0;
      pending_o        <= 0;
      request_count_o  <= 0;
      selected_count_o <= 0;
      no_pick_count_o  <= 0;
      dropped_count_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          flag_error($sformatf("response %0d arrived with no request waiting: status %0d index %0d",
                               n_response, out_rsp_i.status, out_rsp_i.selected_index));
        end else begin
          oldest_rsp = expected_rsp_q.pop_front();
          if (out_rsp_i.status !== oldest_rsp.status ||
              out_rsp_i.selected_index !== oldest_rsp.selected_index) begin
            flag_error($sformatf("response %0d: expected status %0d index %0d, got status %0d index %0d",
                                 n_response, oldest_rsp.status, oldest_rsp.selected_index,
                                 out_rsp_i.status, out_rsp_i.selected_index));
          end
        end
        n_response++;
      end
      if (in_valid_i && !in_stall_i) begin
        next_rsp = apply_request(in_req_i);
        expected_rsp_q = {expected_rsp_q, next_rsp};
        n_request++;
        if (next_rsp.status == ST_SELECTED) n_selected++;
        if (next_rsp.status == ST_NONE) n_no_pick++;
        if (next_rsp.status == ST_FULL) n_dropped++;
      end
      mismatch_count_o <= n_mismatch;
      pending_o        <= expected_rsp_q.size();
      request_count_o  <= n_request;
      selected_count_o <= n_selected;
      no_pick_count_o  <= n_no_pick;
      dropped_count_o  <= n_dropped;
    end
  end

endmodule

FILE: bench/roulette_wheel_select_tb.sv
`timescale 1ns / 100ps

module roulette_wheel_select_tb;
  import rws_pkg::*;

  // The fourth opcode value has no operation behind it.
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 16;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS,
    STALL_TOGGLE
  } stall_mode_e;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic in_valid   = 1'b0;
  logic in_stall;
  req_t in_req     = '0;
  logic out_valid;
  logic out_stall  = 1'b0;
  rsp_t out_rsp;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned request_count;
  int unsigned selected_count;
  int unsigned no_pick_count;
  int unsigned dropped_count;

  stall_mode_e stall_mode = STALL_NONE;
  int unsigned mode_left  = 100;
  int unsigned run_left   = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  bit          drained_midway = 1'b0;

  roulette_wheel_select u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  roulette_wheel_select_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_req_i         (in_req),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_rsp_i        (out_rsp),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count),
    .request_count_o  (request_count),
    .selected_count_o (selected_count),
    .no_pick_count_o  (no_pick_count),
    .dropped_count_o  (dropped_count)
  );

  always #5 clk = ~clk;

  // The response side stalls in randomly chosen modes, each held for a random stretch.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(64, 256);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          out_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 99) < 30);
        end
        STALL_RUNS: begin
          if (run_left == 0) begin
            out_stall <= ~out_stall;
            run_left  <= out_stall ? $urandom_range(1, 10) : $urandom_range(1, 20);
          end else begin
            run_left <= run_left - 1;
          end
        end
        default: begin
          out_stall <= ~out_stall;
        end
      endcase
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles.", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(logic [1:0] op, logic [FIT_W-1:0] fit,
                                    logic [FRAC_W-1:0] frac);
    req_t req;
    req.opcode          = op_e'(op);
    req.fitness_value   = fit;
    req.random_fraction = frac;
    return req;
  endfunction

  // Mix of zero, small, capped, over-cap and full-range fitness values.
  function automatic logic [FIT_W-1:0] pick_fitness();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return FIT_W'($urandom_range(FIT_CAP + 1, 65535));
      2:       return FIT_CAP;
      3, 4, 5: return FIT_W'($urandom_range(1, 512));
      default: return FIT_W'($urandom());
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_fraction();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return '1;
      default: return FRAC_W'($urandom());
    endcase
  endfunction

  // Presents one request and holds it until accepted; bursts end in a random gap.
  task automatic send_request(input req_t req);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Holds off new requests until every outstanding response has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Noise is any opcode with random fields, including restarts that cut a sequence short.
  task automatic send_noise();
    send_request(make_req(2'($urandom_range(0, 3)), FIT_W'($urandom()), FRAC_W'($urandom())));
  endtask

  // Restart, fill the wheel, then spin it a few times, with stray requests mixed in.
  task automatic run_wheel(input int unsigned n_append, input int unsigned n_draw,
                           input bit zero_weights);
    send_request(make_req(OP_RESTART, FIT_W'($urandom()), FRAC_W'($urandom())));
    for (int unsigned i = 0; i < n_append; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_noise();
      end else begin
        send_request(make_req(OP_APPEND, zero_weights ? '0 : pick_fitness(),
                              FRAC_W'($urandom())));
      end
    end
    for (int unsigned i = 0; i < n_draw; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_noise();
      end else begin
        send_request(make_req(OP_DRAW, FIT_W'($urandom()), pick_fraction()));
      end
    end
  endtask

  initial begin
    int unsigned n_append;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, unused opcode and a wheel with no weight.
    send_request(make_req(OP_DRAW, '0, '0));
    send_request(make_req(OP_UNUSED, '1, '1));
    send_request(make_req(OP_APPEND, '0, '1));
    send_request(make_req(OP_DRAW, '1, '0));
    send_request(make_req(OP_DRAW, '0, '1));
    // Saturating appends and a zero-weight entry at the end.
    send_request(make_req(OP_APPEND, '1, '0));
    send_request(make_req(OP_APPEND, FIT_W'(FIT_CAP + 1), '0));
    send_request(make_req(OP_APPEND, FIT_CAP, '0));
    send_request(make_req(OP_APPEND, 16'd1, '0));
    send_request(make_req(OP_APPEND, '0, '0));
    // A zero fraction picks entry 0 even though its weight is zero.
    send_request(make_req(OP_DRAW, '0, '0));
    send_request(make_req(OP_DRAW, '0, '1));
    send_request(make_req(OP_DRAW, '0, 16'h8000));
    send_request(make_req(OP_DRAW, '0, 16'h0001));
    send_request(make_req(OP_UNUSED, '0, '0));
    // Restart empties the table.
    send_request(make_req(OP_RESTART, '1, '1));
    send_request(make_req(OP_DRAW, '0, 16'h1234));
    send_request(make_req(OP_APPEND, 16'h00ff, 16'h5555));
    send_request(make_req(OP_DRAW, 16'haaaa, '1));
    send_request(make_req(OP_DRAW, 16'h5555, '0));

    // The first random wheel overfills the table so appends get dropped.
    items_sent = 0;
    run_wheel(70, 10, 1'b0);
    while (items_sent < RANDOM_ITEMS) begin
      if (!drained_midway && items_sent >= RANDOM_ITEMS / 2) begin
        wait_for_drain();
        drained_midway = 1'b1;
      end
      n_append = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 20);
      run_wheel(n_append, $urandom_range(1, 15), $urandom_range(0, 9) == 0);
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d draws selected an entry, %0d answered with no selection,",
             request_count, selected_count, no_pick_count);
    $display("and %0d appends were dropped on a full table.", dropped_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
